// ===== rtl/core/gcb_pkg.sv =====
`default_nettype none
package gcb_pkg;

    localparam int COORD_BITS  = 12;
    localparam int STRIDE_W    = 15;
    localparam int OFFS_W      = 26;
    localparam int PIX_W       = 32;
    localparam int CH_W        = 8;
    localparam int PROD_W      = 2 * (CH_W + 1);
    localparam int YPROD_W     = COORD_BITS + STRIDE_W;
    localparam int XOFFS_W     = COORD_BITS + 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = STRIDE_W;
    localparam int BD_IDX_W    = 3;

    localparam logic [CH_W-1:0] COV_NONE   = 8'h00;
    localparam logic [CH_W-1:0] COV_FULL   = 8'hff;
    localparam int              COV_FG_BIT = 7;

    typedef enum logic [1:0] {
        FMT_IDX8   = 2'd0,
        FMT_RGB555 = 2'd1,
        FMT_RGB565 = 2'd2,
        FMT_RGB888 = 2'd3
    } t_fmt;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_FORMAT   = 2'd0,
        CFG_LINE_STRIDE    = 2'd1,
        CFG_IMAGE_ENABLE   = 2'd2,
        CFG_BACKDROP_INDEX = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        t_fmt                  fmt;
        logic [STRIDE_W-1:0]   stride;
        logic                  img_en;
        logic [BD_IDX_W-1:0]   bd_idx;
    } t_cfg;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

    function automatic logic [PIX_W-1:0] pack_rgb(
        input t_fmt            fmt,
        input logic [CH_W-1:0] r,
        input logic [CH_W-1:0] g,
        input logic [CH_W-1:0] b
    );
        logic [PIX_W-1:0] p;
        begin
            case (fmt)
                FMT_RGB888: p = {8'h00, r, g, b};
                FMT_RGB565: p = {16'h0000, r[7:3], g[7:2], b[7:3]};
                FMT_RGB555: p = {17'h00000, r[7:3], g[7:3], b[7:3]};
                default:    p = '0;
            endcase
            return p;
        end
    endfunction

    function automatic logic [3*CH_W-1:0] unpack_rgb(
        input t_fmt             fmt,
        input logic [PIX_W-1:0] pix
    );
        logic [3*CH_W-1:0] c;
        begin
            case (fmt)
                FMT_RGB888: c = pix[23:0];
                FMT_RGB565: c = {pix[15:11], 3'b000, pix[10:5], 2'b00, pix[4:0], 3'b000};
                FMT_RGB555: c = {pix[14:10], 3'b000, pix[9:5], 3'b000, pix[4:0], 3'b000};
                default:    c = '0;
            endcase
            return c;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gcb_if.sv =====
`default_nettype none
interface gcb_pix_if import gcb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CH_W-1:0]       coverage;
    logic [CH_W-1:0]       fore_red;
    logic [CH_W-1:0]       fore_green;
    logic [CH_W-1:0]       fore_blue;
    logic [CH_W-1:0]       back_red;
    logic [CH_W-1:0]       back_green;
    logic [CH_W-1:0]       back_blue;
    logic [CH_W-1:0]       fore_index;
    logic [CH_W-1:0]       back_index;
    logic [PIX_W-1:0]      image_pixel;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;

    modport source(
        output valid, coverage, fore_red, fore_green, fore_blue, back_red, back_green,
               back_blue, fore_index, back_index, image_pixel, pixel_x, pixel_y,
        input  ready
    );
    modport sink(
        input  valid, coverage, fore_red, fore_green, fore_blue, back_red, back_green,
               back_blue, fore_index, back_index, image_pixel, pixel_x, pixel_y,
        output ready
    );
endinterface

interface gcb_res_if import gcb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PIX_W-1:0]  pixel_value;
    logic [OFFS_W-1:0] byte_offset;

    modport source(output valid, pixel_value, byte_offset, input ready);
    modport sink(input valid, pixel_value, byte_offset, output ready);
endinterface

interface gcb_cfg_if import gcb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/gcb_cfg_regs.sv =====
`default_nettype none
module gcb_cfg_regs import gcb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gcb_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                CFG_PIXEL_FORMAT:   n_cfg.fmt    = t_fmt'(i_cfg.data[1:0]);
                CFG_LINE_STRIDE:    n_cfg.stride = i_cfg.data[STRIDE_W-1:0];
                CFG_IMAGE_ENABLE:   n_cfg.img_en = i_cfg.data[0];
                CFG_BACKDROP_INDEX: n_cfg.bd_idx = i_cfg.data[BD_IDX_W-1:0];
                default:            n_cfg        = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fmt    <= FMT_RGB565;
            r_cfg.stride <= '0;
            r_cfg.img_en <= 1'b0;
            r_cfg.bd_idx <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/gcb_pixel_pipe.sv =====
`default_nettype none
module gcb_pixel_pipe import gcb_pkg::*; (
    input  wire logic              i_clk,
    input  wire t_stage_en         i_en,
    input  wire t_cfg              i_cfg,
    input  wire logic [CH_W-1:0]   i_coverage,
    input  wire logic [CH_W-1:0]   i_fore_red,
    input  wire logic [CH_W-1:0]   i_fore_green,
    input  wire logic [CH_W-1:0]   i_fore_blue,
    input  wire logic [CH_W-1:0]   i_back_red,
    input  wire logic [CH_W-1:0]   i_back_green,
    input  wire logic [CH_W-1:0]   i_back_blue,
    input  wire logic [CH_W-1:0]   i_fore_index,
    input  wire logic [CH_W-1:0]   i_back_index,
    input  wire logic [PIX_W-1:0]  i_image_pixel,
    output logic      [PIX_W-1:0]  o_pixel_value
);

    logic                 use_img;
    logic [3*CH_W-1:0]    img_rgb;
    logic [CH_W-1:0]      fg [3];
    logic [CH_W-1:0]      bg [3];
    logic [PIX_W-1:0]     bg_pix;
    logic [PIX_W-1:0]     fg_pix;
    logic [CH_W-1:0]      idx_pix;
    logic [PIX_W-1:0]     fixed_pix;
    logic                 do_blend;
    logic [CH_W-1:0]      blended [3];
    logic [PIX_W-1:0]     out_pix;

    logic                 r1_blend;
    t_fmt                 r1_fmt;
    logic [CH_W-1:0]      r1_cov;
    logic [PIX_W-1:0]     r1_fixed;
    logic signed [CH_W:0] r1_diff [3];
    logic [CH_W-1:0]      r1_bg [3];

    logic                 r2_blend;
    t_fmt                 r2_fmt;
    logic [PIX_W-1:0]     r2_fixed;
    logic signed [PROD_W-1:0] r2_prod [3];
    logic [CH_W-1:0]      r2_bg [3];

    logic [PIX_W-1:0]     r3_pix;

    // stage 1: background select, packing, channel differences
    always_comb begin
        use_img = i_cfg.img_en && (i_back_index == {5'b00000, i_cfg.bd_idx});
        img_rgb = unpack_rgb(i_cfg.fmt, i_image_pixel);
        fg[0] = i_fore_red;
        fg[1] = i_fore_green;
        fg[2] = i_fore_blue;
        bg[0] = use_img ? img_rgb[23:16] : i_back_red;
        bg[1] = use_img ? img_rgb[15:8]  : i_back_green;
        bg[2] = use_img ? img_rgb[7:0]   : i_back_blue;
        if (use_img) begin
            bg_pix = (i_cfg.fmt == FMT_RGB888) ? {8'h00, i_image_pixel[23:0]}
                                               : {16'h0000, i_image_pixel[15:0]};
        end else begin
            bg_pix = pack_rgb(i_cfg.fmt, i_back_red, i_back_green, i_back_blue);
        end
        fg_pix = pack_rgb(i_cfg.fmt, i_fore_red, i_fore_green, i_fore_blue);
        if (i_coverage[COV_FG_BIT]) begin
            idx_pix = i_fore_index;
        end else begin
            idx_pix = use_img ? i_image_pixel[7:0] : i_back_index;
        end
        if (i_cfg.fmt == FMT_IDX8) begin
            fixed_pix = {24'h000000, idx_pix};
        end else if (i_coverage == COV_NONE) begin
            fixed_pix = bg_pix;
        end else begin
            fixed_pix = fg_pix;
        end
        do_blend = (i_cfg.fmt != FMT_IDX8) && (i_coverage != COV_NONE)
                   && (i_coverage != COV_FULL);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r1_blend <= do_blend;
            r1_fmt   <= i_cfg.fmt;
            r1_cov   <= i_coverage;
            r1_fixed <= fixed_pix;
            for (int i = 0; i < 3; i++) begin
                r1_diff[i] <= $signed({1'b0, fg[i]}) - $signed({1'b0, bg[i]});
                r1_bg[i]   <= bg[i];
            end
        end
    end

    // stage 2: weight by coverage
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r2_blend <= r1_blend;
            r2_fmt   <= r1_fmt;
            r2_fixed <= r1_fixed;
            for (int i = 0; i < 3; i++) begin
                r2_prod[i] <= r1_diff[i] * $signed({1'b0, r1_cov});
                r2_bg[i]   <= r1_bg[i];
            end
        end
    end

    // stage 3: add back, repack, final select
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            blended[i] = r2_bg[i] + r2_prod[i][15:8];
        end
        out_pix = r2_blend ? pack_rgb(r2_fmt, blended[0], blended[1], blended[2]) : r2_fixed;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r3_pix <= out_pix;
        end
    end

    assign o_pixel_value = r3_pix;

endmodule
`default_nettype wire

// ===== rtl/core/gcb_offset_pipe.sv =====
`default_nettype none
module gcb_offset_pipe import gcb_pkg::*; (
    input  wire logic                  i_clk,
    input  wire t_stage_en             i_en,
    input  wire t_cfg                  i_cfg,
    input  wire logic [COORD_BITS-1:0] i_pixel_x,
    input  wire logic [COORD_BITS-1:0] i_pixel_y,
    output logic      [OFFS_W-1:0]     o_byte_offset
);

    logic [XOFFS_W-1:0] x_bytes;
    logic [YPROD_W-1:0] r1_yprod;
    logic [XOFFS_W-1:0] r1_xbytes;
    logic [OFFS_W-1:0]  r2_offs;
    logic [OFFS_W-1:0]  r3_offs;
    logic [YPROD_W:0]   sum;

    always_comb begin
        case (i_cfg.fmt)
            FMT_IDX8:   x_bytes = {2'b00, i_pixel_x};
            FMT_RGB888: x_bytes = {i_pixel_x, 2'b00};
            default:    x_bytes = {1'b0, i_pixel_x, 1'b0};
        endcase
    end

    assign sum = {1'b0, r1_yprod} + {{(YPROD_W + 1 - XOFFS_W){1'b0}}, r1_xbytes};

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r1_yprod  <= i_pixel_y * i_cfg.stride;
            r1_xbytes <= x_bytes;
        end
        if (i_en.s2) begin
            r2_offs <= sum[OFFS_W-1:0];
        end
        if (i_en.s3) begin
            r3_offs <= r2_offs;
        end
    end

    assign o_byte_offset = r3_offs;

endmodule
`default_nettype wire

// ===== rtl/core/glyph_coverage_color_blend.sv =====
// Channel  Dir  Port    Content
// -------  ---  ------  ---------------------------------------------------
// pixel    in   i_pix   coverage, fg/bg colors and indices, image pixel, x/y
// result   out  o_res   pixel_value, byte_offset
// config   in   i_cfg   index, data (always ready, one register per transaction)
//
// Three register stages; one transaction per clock while o_res.ready allows.
// Throughput is set by the stage handshake: each stage advances when it is
// empty or the next stage advances, so bubbles collapse and a waiting result
// does not block new input while a stage is free.
// Synchronous active-low reset clears stage valid bits and config (fmt RGB565).
`default_nettype none
module glyph_coverage_color_blend import gcb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gcb_cfg_if.sink   i_cfg,
    gcb_pix_if.sink   i_pix,
    gcb_res_if.source o_res
);

    t_cfg      cfg;
    t_stage_en en;
    logic      r_v1;
    logic      r_v2;
    logic      r_v3;
    logic      rdy1;
    logic      rdy2;
    logic      rdy3;

    assign rdy3  = !r_v3 || o_res.ready;
    assign rdy2  = !r_v2 || rdy3;
    assign rdy1  = !r_v1 || rdy2;
    assign en.s1 = rdy1;
    assign en.s2 = rdy2;
    assign en.s3 = rdy3;

    assign i_pix.ready = rdy1;
    assign o_res.valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_pix.valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    gcb_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    gcb_pixel_pipe u_pixel (
        .i_clk         (i_clk),
        .i_en          (en),
        .i_cfg         (cfg),
        .i_coverage    (i_pix.coverage),
        .i_fore_red    (i_pix.fore_red),
        .i_fore_green  (i_pix.fore_green),
        .i_fore_blue   (i_pix.fore_blue),
        .i_back_red    (i_pix.back_red),
        .i_back_green  (i_pix.back_green),
        .i_back_blue   (i_pix.back_blue),
        .i_fore_index  (i_pix.fore_index),
        .i_back_index  (i_pix.back_index),
        .i_image_pixel (i_pix.image_pixel),
        .o_pixel_value (o_res.pixel_value)
    );

    gcb_offset_pipe u_offset (
        .i_clk         (i_clk),
        .i_en          (en),
        .i_cfg         (cfg),
        .i_pixel_x     (i_pix.pixel_x),
        .i_pixel_y     (i_pix.pixel_y),
        .o_byte_offset (o_res.byte_offset)
    );

endmodule
`default_nettype wire
